[src/s512h_pkg.sv]
// Shared types and constants for the SHA-512/256 byte stream hasher.
package s512h_pkg;

	typedef logic [63:0] word_t;

	localparam word_t IV [8] = '{
		64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
		64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2
	};

	localparam word_t ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned ROUNDS = 80;
	localparam int unsigned LEN_LIMIT = 112;

	// commands from controller to datapath
	typedef struct packed {
		logic       put_byte;    // write byte_val at fill position
		logic [7:0] byte_val;
		logic       count_byte;  // bump message byte count
		logic       put_length;  // write length words 14 and 15
		logic       comp_start;  // load working words, clear round count
		logic       comp_round;  // run one round
		logic       comp_finish; // fold into hash, clear block
		logic       restart;     // back to initial values
		logic [1:0] out_sel;
	} s512h_cmd_t;

	typedef struct packed {
		logic [7:0] fill;
		logic       last_round;
		logic [63:0] out_word;
	} s512h_sts_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

endpackage

[src/sha512_256_byte_stream_hasher_unit.sv]
// Top level of the SHA-512/256 byte stream hasher.
// Takes one message byte per request; a byte that completes a 128-byte block starts a
// compression (load, 80 rounds on one round unit, fold). A final request pads, writes the
// length and compresses once or twice, then gives four 64-bit digest words, leftmost first,
// and restarts from the initial values. The input stalls whenever the controller is not
// idle: while padding, compressing a block or sending the digest.
module sha512_256_byte_stream_hasher_unit
	import s512h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        final_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [1:0]  word_number,
	output logic        last_word
);

	s512h_cmd_t cmd;
	s512h_sts_t sts;

	s512h_ctrl u_ctrl (
		.clk, .arst_n, .data_byte, .byte_present, .final_item, .in_valid, .in_stall,
		.out_valid, .out_stall, .word_number, .last_word, .cmd, .sts
	);

	s512h_datapath u_dp (.clk, .arst_n, .cmd, .sts);

	assign digest_word = sts.out_word;

endmodule

[src/s512h_datapath.sv]
// Datapath: block buffer, message schedule, round unit and hash words.
module s512h_datapath
	import s512h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  s512h_cmd_t cmd,
	output s512h_sts_t sts
);

	word_t hash_q [8];
	word_t work_q [8];
	word_t sched_q [16];
	logic [7:0] fill_q;
	logic [63:0] count_q;
	logic [6:0] round_q;

	word_t w15, w2, new_w, t1, t2, big0, big1, ch, maj;
	logic [3:0] wi;
	logic [5:0] sh;

	assign w15  = sched_q[1];
	assign w2   = sched_q[14];
	assign new_w = sched_q[0] + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7)) + sched_q[9]
		+ (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6));
	assign big0 = rotr(work_q[0], 28) ^ rotr(work_q[0], 34) ^ rotr(work_q[0], 39);
	assign big1 = rotr(work_q[4], 14) ^ rotr(work_q[4], 18) ^ rotr(work_q[4], 41);
	assign ch   = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1   = work_q[7] + big1 + ch + ROUND_K[round_q] + sched_q[0];
	assign t2   = big0 + maj;
	assign wi   = fill_q[6:3];
	assign sh   = {~fill_q[2:0], 3'b000};

	assign sts.fill       = fill_q;
	assign sts.last_round = (round_q == 7'(ROUNDS - 1));
	assign sts.out_word   = hash_q[cmd.out_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			round_q <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= IV[i];
				work_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++) sched_q[i] <= '0;
		end else begin
			if (cmd.count_byte) count_q <= count_q + 64'd1;
			if (cmd.put_byte) begin
				sched_q[wi] <= sched_q[wi] | (word_t'(cmd.byte_val) << sh);
				fill_q <= fill_q + 8'd1;
			end
			if (cmd.put_length) begin
				sched_q[14] <= {61'd0, count_q[63:61]};
				sched_q[15] <= {count_q[60:0], 3'b000};
			end
			if (cmd.comp_start) begin
				round_q <= '0;
				for (int i = 0; i < 8; i++) work_q[i] <= hash_q[i];
			end
			if (cmd.comp_round) begin
				round_q <= round_q + 7'd1;
				for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i + 1];
				sched_q[15] <= new_w;
				work_q[7] <= work_q[6];
				work_q[6] <= work_q[5];
				work_q[5] <= work_q[4];
				work_q[4] <= work_q[3] + t1;
				work_q[3] <= work_q[2];
				work_q[2] <= work_q[1];
				work_q[1] <= work_q[0];
				work_q[0] <= t1 + t2;
			end
			if (cmd.comp_finish) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
				for (int i = 0; i < 16; i++) sched_q[i] <= '0;
				fill_q <= '0;
			end
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= IV[i];
				count_q <= '0;
			end
		end
	end

endmodule

[src/s512h_ctrl.sv]
// Controller: request handshake, padding sequence and digest output.
module s512h_ctrl
	import s512h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       final_item,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] word_number,
	output logic       last_word,
	output s512h_cmd_t cmd,
	input  s512h_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PAD, ST_CHECK, ST_LEN, ST_START, ST_ROUND, ST_FOLD, ST_EMIT, ST_DONE
	} state_t;

	state_t state_q;
	logic   final_q;  // finishing a message
	logic   extra_q;  // length does not fit; another block follows
	logic   padded_q; // pad byte already written
	logic [1:0] word_q;
	logic   acc;

	assign acc         = in_valid && (state_q == ST_IDLE);
	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_EMIT);
	assign word_number = word_q;
	assign last_word   = (word_q == 2'd3);

	always_comb begin
		cmd = '0;
		cmd.out_sel = word_q;
		case (state_q)
			ST_IDLE: begin
				cmd.put_byte   = acc && byte_present;
				cmd.count_byte = acc && byte_present;
				cmd.byte_val   = data_byte;
			end
			ST_PAD: begin
				cmd.put_byte = 1'b1;
				cmd.byte_val = PAD_BYTE;
			end
			ST_LEN:   cmd.put_length  = 1'b1;
			ST_START: cmd.comp_start  = 1'b1;
			ST_ROUND: cmd.comp_round  = 1'b1;
			ST_FOLD:  cmd.comp_finish = 1'b1;
			ST_DONE:  cmd.restart     = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			final_q  <= 1'b0;
			extra_q  <= 1'b0;
			padded_q <= 1'b0;
			word_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						final_q  <= final_item;
						extra_q  <= 1'b0;
						padded_q <= 1'b0;
						if (byte_present && sts.fill == 8'd127) state_q <= ST_START;
						else if (final_item) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					padded_q <= 1'b1;
					if (sts.fill == 8'd127) begin
						extra_q <= 1'b1;
						state_q <= ST_START;
					end else state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (sts.fill > 8'(LEN_LIMIT)) begin
						extra_q <= 1'b1;
						state_q <= ST_START;
					end else state_q <= ST_LEN;
				end
				ST_LEN:   state_q <= ST_START;
				ST_START: state_q <= ST_ROUND;
				ST_ROUND: if (sts.last_round) state_q <= ST_FOLD;
				ST_FOLD: begin
					if (!final_q) state_q <= ST_IDLE;
					else if (!padded_q) state_q <= ST_PAD;
					else if (extra_q) begin
						extra_q <= 1'b0;
						state_q <= ST_LEN;
					end else state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						word_q <= word_q + 2'd1;
						if (word_q == 2'd3) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					final_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
